// File: rtl/core/ttt_pkg.sv
package ttt_pkg;

    localparam int ENTRIES   = 16;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 24;
    localparam int TIME_W    = 32;
    localparam int PAY_W     = 64;
    localparam int EXP_W     = 16;

    typedef logic [2:0] status_t;
    localparam status_t ST_UPDATED  = 3'd0;
    localparam status_t ST_FILLED   = 3'd1;
    localparam status_t ST_REPLACED = 3'd2;
    localparam status_t ST_ZERO     = 3'd3;
    localparam status_t ST_OWN      = 3'd4;
    localparam status_t ST_BLOCKED  = 3'd5;
    localparam status_t ST_SWEPT    = 3'd6;
    localparam status_t ST_READ     = 3'd7;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_UPDATE   = 2'd0;
    localparam cmd_t CMD_SWEEP    = 2'd1;
    localparam cmd_t CMD_READ     = 2'd2;
    // spare code, handled as a read
    localparam cmd_t CMD_READ_ALT = 2'd3;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_OWN    = 3'd0;
    localparam reg_idx_t REG_BLK0   = 3'd1;
    localparam reg_idx_t REG_BLK1   = 3'd2;
    localparam reg_idx_t REG_BLK2   = 3'd3;
    localparam reg_idx_t REG_EXPIRY = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] tstamp;
        logic [PAY_W-1:0]  payload;
    } entry_t;

    // configuration seen by every cell
    typedef struct packed {
        logic [ADDR_W-1:0] blk0;
        logic [ADDR_W-1:0] blk1;
        logic [ADDR_W-1:0] blk2;
        logic [EXP_W-1:0]  expiry;
        logic [TIME_W-1:0] now;
    } cell_cfg_t;

    typedef struct packed {
        logic shift;
        logic wr;
        logic clr_blk;
        logic clr_exp;
    } cell_ctl_t;

    function automatic logic is_blocked(input logic [ADDR_W-1:0] a,
                                        input cell_cfg_t c);
        is_blocked = (a != '0) &&
            ((c.blk0 != '0 && a == c.blk0) || (c.blk1 != '0 && a == c.blk1) ||
             (c.blk2 != '0 && a == c.blk2));
    endfunction

    function automatic logic is_expired(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] t,
                                        input logic [EXP_W-1:0] e);
        is_expired = (now > t) && ((now - t) > {{(TIME_W-EXP_W){1'b0}}, e});
    endfunction

endpackage

// File: rtl/core/ttt_cell.sv
// One table slot. On shift the row rotates by one: each cell takes its
// right neighbor's entry, so the head cell sees every slot in turn, in slot
// order. A cleared entry travels on as empty.
module ttt_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ttt_pkg::cell_ctl_t   ctl,
    input  ttt_pkg::cell_cfg_t   cfg,
    input  ttt_pkg::entry_t      wr_entry,
    input  ttt_pkg::entry_t      shift_in,
    output ttt_pkg::entry_t      entry,
    output ttt_pkg::entry_t      fwd,
    output logic                 removed
);
    ttt_pkg::entry_t entry_reg, entry_next, cur, kept;
    logic            blk, exp_hit;

    always_comb begin
        cur     = ctl.wr ? wr_entry : entry_reg;
        blk     = ttt_pkg::is_blocked(cur.addr, cfg);
        exp_hit = (cur.addr != '0) &&
                  ttt_pkg::is_expired(cfg.now, cur.tstamp, cfg.expiry);
        removed = (ctl.clr_blk && blk) || (ctl.clr_exp && exp_hit);
        kept    = removed ? '0 : cur;
        entry_next = ctl.shift ? shift_in : kept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign fwd   = kept;
endmodule

// File: rtl/core/ttt_ring.sv
// Row of cells in a ring. Cell 0 is the head: writes land there.
module ttt_ring (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift,
    input  logic                 head_wr,
    input  logic                 clr_blk,
    input  logic                 clr_exp,
    input  ttt_pkg::cell_cfg_t   cfg,
    input  ttt_pkg::entry_t      wr_entry,
    output ttt_pkg::entry_t      head,
    output logic [ttt_pkg::CNT_W-1:0] occupied,
    output logic [ttt_pkg::CNT_W-1:0] removed
);
    ttt_pkg::entry_t entries [ttt_pkg::ENTRIES];
    ttt_pkg::entry_t fwds [ttt_pkg::ENTRIES];
    logic [ttt_pkg::ENTRIES-1:0] rm;
    ttt_pkg::cell_ctl_t ctl [ttt_pkg::ENTRIES];

    for (genvar i = 0; i < ttt_pkg::ENTRIES; i++) begin : g_cell
        assign ctl[i] = '{shift: shift, wr: head_wr && (i == 0),
                          clr_blk: clr_blk, clr_exp: clr_exp};
        ttt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl[i]),
            .cfg      (cfg),
            .wr_entry (wr_entry),
            .shift_in (fwds[(i + 1) % ttt_pkg::ENTRIES]),
            .entry    (entries[i]),
            .fwd      (fwds[i]),
            .removed  (rm[i])
        );
    end

    always_comb begin
        occupied = '0;
        removed  = '0;
        for (int i = 0; i < ttt_pkg::ENTRIES; i++) begin
            occupied = occupied + ttt_pkg::CNT_W'(entries[i].addr != '0);
            removed  = removed + ttt_pkg::CNT_W'(rm[i]);
        end
    end

    assign head = entries[0];
endmodule

// File: rtl/core/tracked_target_table.sv
// Tracked target table, 16 slots keyed by a nonzero 24-bit address.
// Requests enter on the s_axis channel (tdata: command, address, record_time,
// record_payload, now_seconds, slot_index), results leave on m_axis, one per
// request. Configuration writes use cfg_valid/cfg_ready with cfg_index and
// cfg_data and are taken at any time; write only while the block is idle.
// The slots sit in a ring of cells that rotates one position per cycle,
// while shifting, past a head cell. An update walks the ring once for a
// matching slot, a free slot and the victim, picks one in PICK, rotates the
// chosen slot to the head, writes it and rotates home. A sweep takes two
// rotations (blocked, then expired), a read one. Every result, also that of
// a rejected update, which skips the ring, is loaded into the output
// register in DONE, and the input is ready again as it is loaded. One
// request is in flight at a time; a new request is taken while the previous
// result waits in the output register. A stalled receiver holds the result
// and blocks further requests once one more has finished. Reset empties
// every slot and sets the expiry to 10 seconds, the other configuration
// registers to zero.
module tracked_target_table (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // command[1:0], address[25:2], record_time[57:26], record_payload[121:58],
    // now_seconds[153:122], slot_index[157:154]
    input  logic [159:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[2:0], slot[6:3], entry_address[30:7], entry_time[62:31],
    // entry_payload[126:63], occupied_count[131:127], removed_count[136:132]
    output logic [135+8:0] m_axis_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    localparam int SW = ttt_pkg::SLOT_W;
    localparam int CW = ttt_pkg::CNT_W;

    typedef enum logic [2:0] {
        IDLE, SCAN, PICK, PLACE, WRITE, HOME, SWEEP2, DONE
    } state_t;

    state_t state_reg;
    logic [23:0] own_reg, blk0_reg, blk1_reg, blk2_reg;
    logic [15:0] exp_reg;

    logic [1:0]   cmd_reg;
    logic [23:0]  addr_reg;
    logic [31:0]  time_reg, now_reg;
    logic [63:0]  pay_reg;
    logic [SW-1:0] sidx_reg;

    logic [SW-1:0] cnt_reg;      // rotation counter, head holds slot cnt
    logic          match_v_reg, free_v_reg, stop_reg;
    logic [SW-1:0] match_reg, free_reg, vic_reg;
    logic [31:0]   tmin_reg;
    logic [SW-1:0] target_reg;
    logic [2:0]    st_reg;
    logic [CW-1:0] rem_reg;
    ttt_pkg::entry_t rd_reg;

    logic          ovalid_reg;
    logic [143:0]  odata_reg;

    ttt_pkg::cell_cfg_t cfg;
    ttt_pkg::entry_t    head, wr_entry;
    logic [CW-1:0]      occ, rem;
    logic               shift, head_wr, clr_blk, clr_exp;
    logic [SW-1:0]      pos;
    logic               accept, blk_in, done_ok, in_upd;

    assign cfg = '{blk0: blk0_reg, blk1: blk1_reg, blk2: blk2_reg,
                   expiry: exp_reg, now: now_reg};
    assign pos = cnt_reg;
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign done_ok = !ovalid_reg || m_axis_tready;
    assign blk_in = ttt_pkg::is_blocked(s_axis_tdata[25:2], cfg);
    assign in_upd = (s_axis_tdata[1:0] == ttt_pkg::CMD_UPDATE);

    assign wr_entry = '{addr: addr_reg,
                        tstamp: (time_reg == '0) ? now_reg : time_reg,
                        payload: pay_reg};

    always_comb begin
        shift   = (state_reg == SCAN) || (state_reg == SWEEP2) ||
                  (state_reg == HOME) ||
                  ((state_reg == PLACE) && (pos != target_reg));
        head_wr = (state_reg == WRITE);
        clr_blk = (state_reg == SCAN) && (cmd_reg == ttt_pkg::CMD_SWEEP);
        clr_exp = (state_reg == SWEEP2);
    end

    ttt_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift    (shift),
        .head_wr  (head_wr),
        .clr_blk  (clr_blk),
        .clr_exp  (clr_exp),
        .cfg      (cfg),
        .wr_entry (wr_entry),
        .head     (head),
        .occupied (occ),
        .removed  (rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            own_reg    <= '0;
            blk0_reg   <= '0;
            blk1_reg   <= '0;
            blk2_reg   <= '0;
            exp_reg    <= 16'd10;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ttt_pkg::REG_OWN:    own_reg  <= cfg_data;
                    ttt_pkg::REG_BLK0:   blk0_reg <= cfg_data;
                    ttt_pkg::REG_BLK1:   blk1_reg <= cfg_data;
                    ttt_pkg::REG_BLK2:   blk2_reg <= cfg_data;
                    ttt_pkg::REG_EXPIRY: exp_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tready && !(state_reg == DONE && done_ok)) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (accept) begin
                        cmd_reg  <= s_axis_tdata[1:0];
                        addr_reg <= s_axis_tdata[25:2];
                        time_reg <= s_axis_tdata[57:26];
                        pay_reg  <= s_axis_tdata[121:58];
                        now_reg  <= s_axis_tdata[153:122];
                        sidx_reg <= s_axis_tdata[157:154];
                        cnt_reg  <= '0;
                        match_v_reg <= 1'b0;
                        free_v_reg  <= 1'b0;
                        stop_reg    <= 1'b0;
                        rem_reg     <= '0;
                        rd_reg      <= '0;
                        if (in_upd && s_axis_tdata[25:2] == '0) begin
                            st_reg <= ttt_pkg::ST_ZERO;
                            state_reg <= DONE;
                        end else if (in_upd && blk_in) begin
                            st_reg <= ttt_pkg::ST_BLOCKED;
                            state_reg <= DONE;
                        end else if (in_upd && s_axis_tdata[25:2] == own_reg) begin
                            st_reg <= ttt_pkg::ST_OWN;
                            state_reg <= DONE;
                        end else begin
                            state_reg <= SCAN;
                        end
                    end
                end
                SCAN: begin
                    // counter wraps to zero as the ring comes home
                    cnt_reg <= cnt_reg + SW'(1);
                    if (pos == sidx_reg) begin
                        rd_reg <= head;
                    end
                    if (!match_v_reg && head.addr == addr_reg) begin
                        match_v_reg <= 1'b1;
                        match_reg   <= pos;
                    end
                    if (!free_v_reg && head.addr == '0) begin
                        free_v_reg <= 1'b1;
                        free_reg   <= pos;
                    end
                    if (pos == '0) begin
                        vic_reg  <= '0;
                        tmin_reg <= head.tstamp;
                    end else if (!stop_reg) begin
                        if (ttt_pkg::is_expired(now_reg, head.tstamp, exp_reg)) begin
                            vic_reg  <= pos;
                            stop_reg <= 1'b1;
                        end else if (head.tstamp < tmin_reg) begin
                            vic_reg  <= pos;
                            tmin_reg <= head.tstamp;
                        end
                    end
                    rem_reg <= rem_reg + rem;
                    if (cnt_reg == SW'(ttt_pkg::ENTRIES - 1)) begin
                        if (cmd_reg == ttt_pkg::CMD_UPDATE) begin
                            state_reg <= PICK;
                        end else if (cmd_reg == ttt_pkg::CMD_SWEEP) begin
                            state_reg <= SWEEP2;
                        end else begin
                            st_reg    <= ttt_pkg::ST_READ;
                            state_reg <= DONE;
                        end
                    end
                end
                PICK: begin
                    if (match_v_reg) begin
                        target_reg <= match_reg;
                        st_reg     <= ttt_pkg::ST_UPDATED;
                    end else if (free_v_reg) begin
                        target_reg <= free_reg;
                        st_reg     <= ttt_pkg::ST_FILLED;
                    end else begin
                        target_reg <= vic_reg;
                        st_reg     <= ttt_pkg::ST_REPLACED;
                    end
                    state_reg <= PLACE;
                end
                PLACE: begin
                    // rotate until the chosen slot sits in the head cell
                    if (pos == target_reg) begin
                        state_reg <= WRITE;
                    end else begin
                        cnt_reg <= cnt_reg + SW'(1);
                    end
                end
                WRITE: begin
                    if (pos == '0) begin
                        state_reg <= DONE;
                    end else begin
                        state_reg <= HOME;
                    end
                end
                HOME: begin
                    cnt_reg <= cnt_reg + SW'(1);
                    if (cnt_reg == SW'(ttt_pkg::ENTRIES - 1)) begin
                        state_reg <= DONE;
                    end
                end
                SWEEP2: begin
                    cnt_reg <= cnt_reg + SW'(1);
                    rem_reg <= rem_reg + rem;
                    if (cnt_reg == SW'(ttt_pkg::ENTRIES - 1)) begin
                        st_reg    <= ttt_pkg::ST_SWEPT;
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    if (done_ok) begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= {7'd0,
                            (st_reg == ttt_pkg::ST_SWEPT) ? rem_reg : CW'(0), occ,
                            (st_reg == ttt_pkg::ST_READ) ? rd_reg.payload : 64'd0,
                            (st_reg == ttt_pkg::ST_READ) ? rd_reg.tstamp : 32'd0,
                            (st_reg == ttt_pkg::ST_READ) ? rd_reg.addr : 24'd0,
                            (st_reg == ttt_pkg::ST_READ) ? sidx_reg :
                            ((st_reg <= ttt_pkg::ST_REPLACED) ? target_reg : SW'(0)),
                            st_reg};
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
